FILE: hdl/rtcep_pkg.sv
`default_nettype none

package rtcep_pkg;

  localparam int HMS_W  = 17;   // seconds within a day, up to 86400
  localparam int DAYS_W = 18;   // signed day count since the base year

  localparam logic CMD_FULL  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [31:0] DAY_SECONDS = 32'd86400;

  // Work item passed from the front end to the back end
  typedef struct packed {
    logic              cmd;
    logic [HMS_W-1:0]  hms;
    logic [4:0]        day;
    logic [DAYS_W-1:0] days;
  } rtcep_item_t;

  // floor((month + 1) * 30.6) for months from March on; January and
  // February hold their direct offset (the leap rule does not touch them).
  function automatic logic [9:0] month_base(input logic [3:0] month_index);
    logic [9:0] base;
    case (month_index)
      4'd0:    base = 10'd0;
      4'd1:    base = 10'd31;
      4'd2:    base = 10'd122;
      4'd3:    base = 10'd153;
      4'd4:    base = 10'd183;
      4'd5:    base = 10'd214;
      4'd6:    base = 10'd244;
      4'd7:    base = 10'd275;
      4'd8:    base = 10'd306;
      4'd9:    base = 10'd336;
      4'd10:   base = 10'd367;
      4'd11:   base = 10'd397;
      4'd12:   base = 10'd428;
      4'd13:   base = 10'd459;
      4'd14:   base = 10'd489;
      4'd15:   base = 10'd520;
      default: base = 10'd0;
    endcase
    return base;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rtcep_front.sv
`default_nettype none

module rtcep_front import rtcep_pkg::*; #(
  parameter int BASE_YEAR = 70
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire logic              cmd,
  input  wire logic [5:0]        second,
  input  wire logic [5:0]        minute,
  input  wire logic [4:0]        hour,
  input  wire logic [4:0]        day_of_month,
  input  wire logic [3:0]        month_index,
  input  wire logic [7:0]        year_since_1900,
  output logic                   push,
  output rtcep_item_t            push_item,
  input  wire logic              queue_ready
);

  localparam int LEAP_YEAR  = 1899 + BASE_YEAR;
  localparam int LEAP_BASE  = LEAP_YEAR / 4 - LEAP_YEAR / 100 + LEAP_YEAR / 400;
  localparam logic [7:0]        BASE_Y8   = 8'(BASE_YEAR);
  localparam logic [DAYS_W-1:0] LEAP_B18  = DAYS_W'(LEAP_BASE);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CALC = 2'd1;
  localparam logic [1:0] F_SUM  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0] state;

  logic       r_cmd;
  logic [5:0] r_sec;
  logic [5:0] r_min;
  logic [4:0] r_hr;
  logic [4:0] r_day;
  logic [3:0] r_mon;
  logic [7:0] r_yr;

  logic [9:0]        moff;
  logic [DAYS_W-1:0] ydays;
  logic [HMS_W-1:0]  hms;
  logic [DAYS_W-1:0] days;

  logic              leap;
  logic [9:0]        base;
  logic [9:0]        moff_next;
  logic [11:0]       full_m1;
  logic [4:0]        cent;
  logic [2:0]        quad;
  logic [9:0]        leaps_yr;
  logic [7:0]        nyears;
  logic [DAYS_W-1:0] ydays_next;
  logic [HMS_W-1:0]  hms_next;

  assign item_stall = (state != F_IDLE);

  // Gregorian rule on 1900 + year; only 1900, 2000 and 2100 are centuries here
  assign leap = (r_yr[1:0] == 2'b00) && (r_yr != 8'd0) && (r_yr != 8'd200);

  always_comb begin
    base = month_base(r_mon);
    if (r_mon < 4'd2) begin
      moff_next = base;
    end else begin
      moff_next = base - 10'd63 + 10'(leap);
    end
  end

  // leap years in 1..(1899 + year)
  always_comb begin
    full_m1 = 12'd1899 + 12'(r_yr);
    if (r_yr == 8'd0) begin
      cent = 5'd18;
    end else if (r_yr <= 8'd100) begin
      cent = 5'd19;
    end else if (r_yr <= 8'd200) begin
      cent = 5'd20;
    end else begin
      cent = 5'd21;
    end
    quad     = (r_yr <= 8'd100) ? 3'd4 : 3'd5;
    leaps_yr = 10'(full_m1 >> 2) - 10'(cent) + 10'(quad);
    nyears   = r_yr - BASE_Y8;
    if (r_yr > BASE_Y8) begin
      ydays_next = DAYS_W'(nyears) * DAYS_W'(365) + DAYS_W'(leaps_yr) - LEAP_B18;
    end else begin
      ydays_next = '0;
    end
  end

  assign hms_next = HMS_W'(r_sec) + HMS_W'(r_min) * HMS_W'(60) + HMS_W'(r_hr) * HMS_W'(3600);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (item_valid) state <= F_CALC;
        end
        F_CALC: state <= F_SUM;
        F_SUM:  state <= F_PUSH;
        F_PUSH: begin
          if (queue_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && item_valid) begin
      r_cmd <= cmd;
      r_sec <= second;
      r_min <= minute;
      r_hr  <= hour;
      r_day <= day_of_month;
      r_mon <= month_index;
      r_yr  <= year_since_1900;
    end
    if (state == F_CALC) begin
      moff  <= moff_next;
      ydays <= ydays_next;
      hms   <= hms_next;
    end
    // day of month zero wraps to minus one, as in the modular sum
    if (state == F_SUM) begin
      days <= DAYS_W'(r_day) - DAYS_W'(1) + DAYS_W'(moff) + ydays;
    end
  end

  assign push           = (state == F_PUSH) && queue_ready;
  assign push_item.cmd  = r_cmd;
  assign push_item.hms  = hms;
  assign push_item.day  = r_day;
  assign push_item.days = days;

endmodule

`default_nettype wire

FILE: hdl/rtcep_queue.sv
`default_nettype none

module rtcep_queue import rtcep_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  rtcep_item_t      push_item,
  output logic             ready,
  output logic             valid,
  input  wire logic        pop,
  output rtcep_item_t      head
);

  rtcep_item_t mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign ready = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

FILE: hdl/rtcep_back.sv
`default_nettype none

module rtcep_back import rtcep_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        epoch_offset_we,
  input  wire logic [17:0] epoch_offset,
  input  wire logic        queue_valid,
  input  rtcep_item_t      queue_head,
  output logic             pop,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [31:0]      epoch_seconds
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL  = 2'd1;
  localparam logic [1:0] B_SUM  = 2'd2;
  localparam logic [1:0] B_OUT  = 2'd3;

  logic [1:0]       state;
  logic [17:0]      offset;
  rtcep_item_t      cur;
  logic             full;
  logic [31:0]      prod;
  logic [31:0]      res;

  logic [31:0]      kept_seconds;
  logic [HMS_W-1:0] kept_hms;
  logic [4:0]       kept_day;

  logic [31:0]      res_next;
  logic [31:0]      days_ext;
  logic [31:0]      off_ext;
  logic             load_out;

  assign pop      = (state == B_IDLE) && queue_valid;
  assign days_ext = {{(32 - DAYS_W){cur.days[DAYS_W-1]}}, cur.days};
  assign off_ext  = {{14{offset[17]}}, offset};
  assign load_out = (state == B_OUT) && (!result_valid || !result_stall);

  always_comb begin
    if (full) begin
      res_next = 32'(cur.hms) + prod + off_ext;
    end else begin
      // same day: move the kept time by the change in time of day
      res_next = kept_seconds + 32'(cur.hms) - 32'(kept_hms);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      offset       <= '0;
      kept_seconds <= '0;
      kept_hms     <= '0;
      kept_day     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (epoch_offset_we) offset <= epoch_offset;
      case (state)
        B_IDLE: begin
          if (queue_valid) state <= B_MUL;
        end
        B_MUL: state <= B_SUM;
        B_SUM: begin
          kept_seconds <= res_next;
          kept_hms     <= cur.hms;
          if (full) kept_day <= cur.day;
          state <= B_OUT;
        end
        B_OUT: begin
          if (load_out) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= queue_head;
    if (state == B_MUL) begin
      prod <= days_ext * DAY_SECONDS;
      full <= (cur.cmd == CMD_FULL) || (kept_seconds == 32'd0) || (kept_day != cur.day);
    end
    if (state == B_SUM) res <= res_next;
    if (load_out) epoch_seconds <= res;
  end

endmodule

`default_nettype wire

FILE: hdl/rtc_fields_to_epoch_seconds.sv
// Converts real-time-clock readings to seconds since the start of the
// base year (1900 + BASE_YEAR), modulo 2^32.
//
// Input channel: item_valid / item_stall with cmd and the clock fields.
// cmd = 0 always does a full calendar conversion; cmd = 1 does one only if
// the kept time is zero or the day of month changed, and otherwise moves
// the kept time by the change in hour, minute and second.
// Output channel: result_valid / result_stall with epoch_seconds, one
// result per item, in order.
// epoch_offset_we writes epoch_offset (signed seconds added to full
// conversions); write it only while no item is in flight.
//
// The front end registers each item through capture, calendar terms, day
// sum and queue write, and takes no new item until it has written the last
// one to the queue; the back end works on one item at a time through pop,
// day-to-seconds multiply, final add and output load. A two-entry queue
// sits between the two.
// Reset clears the kept time, the offset and the queue. While result_stall
// is high the result holds, the queue fills and then item_stall rises.
`default_nettype none

module rtc_fields_to_epoch_seconds import rtcep_pkg::*; #(
  parameter int BASE_YEAR = 70
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        epoch_offset_we,
  input  wire logic [17:0] epoch_offset,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic        cmd,
  input  wire logic [5:0]  second,
  input  wire logic [5:0]  minute,
  input  wire logic [4:0]  hour,
  input  wire logic [4:0]  day_of_month,
  input  wire logic [3:0]  month_index,
  input  wire logic [7:0]  year_since_1900,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [31:0]      epoch_seconds
);

  logic        push;
  rtcep_item_t push_item;
  logic        queue_ready;
  logic        queue_valid;
  logic        pop;
  rtcep_item_t queue_head;

  rtcep_front #(
    .BASE_YEAR(BASE_YEAR)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .cmd            (cmd),
    .second         (second),
    .minute         (minute),
    .hour           (hour),
    .day_of_month   (day_of_month),
    .month_index    (month_index),
    .year_since_1900(year_since_1900),
    .push           (push),
    .push_item      (push_item),
    .queue_ready    (queue_ready)
  );

  rtcep_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .ready    (queue_ready),
    .valid    (queue_valid),
    .pop      (pop),
    .head     (queue_head)
  );

  rtcep_back u_back (
    .clk            (clk),
    .rst            (rst),
    .epoch_offset_we(epoch_offset_we),
    .epoch_offset   (epoch_offset),
    .queue_valid    (queue_valid),
    .queue_head     (queue_head),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .epoch_seconds  (epoch_seconds)
  );

endmodule

`default_nettype wire

FILE: hdl/rtcep_checker.sv
`default_nettype none

module rtcep_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        epoch_offset_we,
  input wire logic [17:0] epoch_offset,
  input wire logic        item_valid,
  input wire logic        item_stall,
  input wire logic        cmd,
  input wire logic [5:0]  second,
  input wire logic [5:0]  minute,
  input wire logic [4:0]  hour,
  input wire logic [4:0]  day_of_month,
  input wire logic [3:0]  month_index,
  input wire logic [7:0]  year_since_1900,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire logic [31:0] epoch_seconds
);

  a_reset_no_result: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> !item_stall)
    else $error("front end not ready after reset");

  // front end stays busy after taking each item, through the calendar terms and day sum
  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall ##1 item_stall)
    else $error("item taken while front end busy");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(epoch_seconds)))
    else $error("stalled result changed");

endmodule

bind rtc_fields_to_epoch_seconds rtcep_checker u_chk (.*);

`default_nettype wire

FILE: verif/rtc_fields_to_epoch_seconds_tb.sv
`default_nettype none

module rtc_fields_to_epoch_seconds_tb import rtcep_pkg::*;;

  localparam int BASE_YEAR = 70;
  localparam int PHASES = 7;

  typedef struct {
    logic       cmd;
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hr;
    logic [4:0] mday;
    logic [3:0] mon;
    logic [7:0] yr;
  } clock_reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        epoch_offset_we = 1'b0;
  logic [17:0] epoch_offset = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        cmd = 1'b0;
  logic [5:0]  second = '0;
  logic [5:0]  minute = '0;
  logic [4:0]  hour = '0;
  logic [4:0]  day_of_month = '0;
  logic [3:0]  month_index = '0;
  logic [7:0]  year_since_1900 = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [31:0] epoch_seconds;

  rtc_fields_to_epoch_seconds #(.BASE_YEAR(BASE_YEAR)) dut (
    .clk(clk),
    .rst(rst),
    .epoch_offset_we(epoch_offset_we),
    .epoch_offset(epoch_offset),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .cmd(cmd),
    .second(second),
    .minute(minute),
    .hour(hour),
    .day_of_month(day_of_month),
    .month_index(month_index),
    .year_since_1900(year_since_1900),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .epoch_seconds(epoch_seconds)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [31:0] kept_total = '0;
  logic [5:0]  kept_sec = '0;
  logic [5:0]  kept_min = '0;
  logic [4:0]  kept_hr = '0;
  logic [4:0]  kept_mday = '0;
  logic [17:0] offset_setting = '0;

  clock_reading_t pending_readings[$];
  logic [31:0]    expected_seconds[$];
  clock_reading_t on_wire;
  int readings_queued = 0;
  int readings_accepted = 0;
  int errors = 0;
  int gap_max = 0;
  int stall_mode = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  logic stall_now = 1'b0;

  // leap years in 1..n
  function automatic logic [31:0] leaps_upto(input logic [31:0] n);
    return n / 32'd4 - n / 32'd100 + n / 32'd400;
  endfunction

  function automatic logic [31:0] calendar_seconds(input clock_reading_t r);
    logic [31:0] yr;
    logic [31:0] full_year;
    logic [31:0] lp;
    logic [31:0] mon;
    logic [31:0] moff;
    logic [31:0] days;
    logic [31:0] off;
    yr = 32'(r.yr);
    full_year = 32'd1900 + yr;
    lp = (((full_year % 32'd4 == 0) && (full_year % 32'd100 != 0)) ||
          (full_year % 32'd400 == 0)) ? 32'd1 : 32'd0;
    mon = 32'(r.mon);
    mon = mon + 32'd1;
    if (mon <= 32'd2) begin
      moff = ((mon - 32'd1) * (32'd63 - lp)) / 32'd2;
    end else begin
      moff = ((mon + 32'd1) * 32'd306) / 32'd10 - (32'd63 - lp);
    end
    days = 32'(r.mday);
    days = days - 32'd1 + moff;
    if (yr > BASE_YEAR) begin
      days = days + 32'd365 * (yr - BASE_YEAR) + leaps_upto(32'd1899 + yr)
             - leaps_upto(32'd1899 + BASE_YEAR);
    end
    off = {{14{offset_setting[17]}}, offset_setting};
    return 32'(r.sec) + 32'(r.min) * 32'd60 + 32'(r.hr) * 32'd3600
           + days * 32'd86400 + off;
  endfunction

  // Updates the kept clock for one reading and returns the expected seconds.
  function automatic logic [31:0] advance_clock(input clock_reading_t r);
    logic [31:0] old_s;
    logic [31:0] new_s;
    if (r.cmd == CMD_FULL || kept_total == 32'd0 || kept_mday != r.mday) begin
      kept_total = calendar_seconds(r);
      kept_mday = r.mday;
    end else begin
      old_s = 32'(kept_sec) + 32'(kept_min) * 32'd60 + 32'(kept_hr) * 32'd3600;
      new_s = 32'(r.sec) + 32'(r.min) * 32'd60 + 32'(r.hr) * 32'd3600;
      kept_total = kept_total + new_s - old_s;
    end
    kept_sec = r.sec;
    kept_min = r.min;
    kept_hr = r.hr;
    return kept_total;
  endfunction

  task automatic add_reading(input logic c, input int s, input int mi, input int h,
                             input int d, input int mo, input int y);
    clock_reading_t r;
    r.cmd = c;
    r.sec = s[5:0];
    r.min = mi[5:0];
    r.hr = h[4:0];
    r.mday = d[4:0];
    r.mon = mo[3:0];
    r.yr = y[7:0];
    pending_readings.push_back(r);
    readings_queued++;
  endtask

  task automatic queue_directed_readings();
    // kept time zero forces a full conversion even on a query
    add_reading(CMD_QUERY, 0, 0, 0, 1, 0, 70);
    add_reading(CMD_QUERY, 0, 0, 0, 1, 0, 70);
    add_reading(CMD_FULL, 1, 0, 0, 1, 0, 70);
    add_reading(CMD_QUERY, 60, 59, 23, 1, 0, 70);
    add_reading(CMD_QUERY, 0, 0, 0, 1, 0, 70);  // time runs backwards
    add_reading(CMD_QUERY, 5, 5, 5, 2, 0, 70);  // day changed
    add_reading(CMD_FULL, 0, 0, 0, 1, 0, 0);    // year before base
    add_reading(CMD_FULL, 59, 59, 23, 31, 11, 69);
    add_reading(CMD_FULL, 0, 0, 0, 28, 1, 71);
    add_reading(CMD_FULL, 0, 0, 12, 29, 1, 100);  // 2000 is leap
    add_reading(CMD_FULL, 0, 0, 0, 1, 2, 100);
    add_reading(CMD_FULL, 0, 0, 0, 1, 2, 200);    // 2100 is not
    add_reading(CMD_FULL, 0, 0, 0, 1, 12, 120);   // month out of range
    add_reading(CMD_FULL, 0, 0, 0, 1, 15, 120);
    add_reading(CMD_FULL, 0, 0, 0, 0, 5, 90);     // day zero
    add_reading(CMD_FULL, 63, 63, 31, 31, 15, 255);
    add_reading(CMD_QUERY, 0, 0, 0, 31, 15, 255);
    add_reading(CMD_QUERY, 63, 63, 31, 31, 0, 0);
    add_reading(CMD_QUERY, 63, 63, 31, 31, 15, 255);
    add_reading(CMD_FULL, 30, 30, 10, 15, 6, 124);
    add_reading(CMD_QUERY, 31, 30, 10, 15, 6, 124);
  endtask

  // Mostly clock sessions: a full read, then queries on the same day.
  task automatic queue_random_readings(input int count);
    int made;
    int n;
    int y;
    int mo;
    int d;
    logic c;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 7) == 0) begin
        add_reading(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
        made++;
      end else begin
        y = $urandom_range(0, 255);
        mo = $urandom_range(0, 11);
        d = $urandom_range(1, 31);
        c = ($urandom_range(0, 3) == 0) ? CMD_QUERY : CMD_FULL;
        add_reading(c, $urandom_range(0, 60), $urandom_range(0, 59),
                    $urandom_range(0, 23), d, mo, y);
        made++;
        n = $urandom_range(2, 10);
        for (int j = 0; j < n; j++) begin
          if ($urandom_range(0, 7) == 0) begin
            d = $urandom_range(1, 31);
          end
          c = ($urandom_range(0, 9) == 0) ? CMD_FULL : CMD_QUERY;
          if ($urandom_range(0, 9) == 0) begin
            add_reading(c, $urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom_range(0, 31), d, mo, y);
          end else begin
            add_reading(c, $urandom_range(0, 60), $urandom_range(0, 59),
                        $urandom_range(0, 23), d, mo, y);
          end
          made++;
        end
      end
    end
  endtask

  // Driver: bursts of items with random gaps
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (item_valid && !item_stall) begin
        expected_seconds.push_back(advance_clock(on_wire));
        readings_accepted++;
      end
      if (!item_valid || !item_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (pending_readings.size() > 0) begin
          on_wire = pending_readings.pop_front();
          cmd <= on_wire.cmd;
          second <= on_wire.sec;
          minute <= on_wire.min;
          hour <= on_wire.hr;
          day_of_month <= on_wire.mday;
          month_index <= on_wire.mon;
          year_since_1900 <= on_wire.yr;
          item_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_seconds.size() == 0) begin
          $display("%0t: epoch_seconds expected none, got %h", $time, epoch_seconds);
          errors++;
        end else if (epoch_seconds !== expected_seconds[0]) begin
          $display("%0t: epoch_seconds expected %h, got %h", $time,
                   expected_seconds[0], epoch_seconds);
          errors++;
          void'(expected_seconds.pop_front());
        end else begin
          void'(expected_seconds.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else begin
        case (stall_mode)
          1: begin
            stall_now = ($urandom_range(0, 3) == 0);
            stall_left = $urandom_range(0, 3);
          end
          2: begin
            stall_now = ($urandom_range(0, 3) != 0);
            stall_left = $urandom_range(0, 11);
          end
          3: begin
            stall_now = 1'($urandom_range(0, 1));
            stall_left = $urandom_range(0, 39);
          end
          default: begin
            stall_now = 1'b0;
            stall_left = $urandom_range(0, 31);
          end
        endcase
      end
      result_stall <= stall_now;
    end
  end

  initial begin
    int offsets[PHASES];
    int gaps[PHASES];
    int stalls[PHASES];
    offsets = '{0, 86400, -86400, 131071, -131072, 0, 0};
    gaps = '{0, 3, 8, 0, 12, 1, 5};
    stalls = '{0, 1, 2, 3, 0, 2, 1};
    offsets[5] = $urandom_range(0, 172800);
    offsets[5] = offsets[5] - 86400;
    offsets[6] = $urandom;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < PHASES; phase++) begin
      // block is idle here: nothing queued and nothing in flight
      @(posedge clk);
      epoch_offset_we <= 1'b1;
      epoch_offset <= offsets[phase][17:0];
      offset_setting = offsets[phase][17:0];
      @(posedge clk);
      epoch_offset_we <= 1'b0;
      gap_max = gaps[phase];
      stall_mode = stalls[phase];
      if (phase == 0) begin
        queue_directed_readings();
      end else begin
        queue_random_readings(125);
      end
      while (!(readings_accepted == readings_queued && expected_seconds.size() == 0)) begin
        @(posedge clk);
      end
      repeat (12) @(posedge clk);
    end
    if (errors == 0) begin
      $display("rtc_fields_to_epoch_seconds: match");
    end else begin
      $display("rtc_fields_to_epoch_seconds: mismatch");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("rtc_fields_to_epoch_seconds: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
